[rtl/pscrl_pkg.sv]
// Shared types and codes for the per-source connection rate limiter.
package pscrl_pkg;

   localparam int ADDR_W  = 32;
   localparam int TIME_W  = 48;
   localparam int COUNT_W = 16;

   localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [15:0] WINDOW_MS_RESET = 16'd1000;
   localparam logic [15:0] MAX_PER_WINDOW_RESET = 16'd10;
   localparam logic [31:0] BLOCK_MS_RESET = 32'd10000;

   typedef enum logic [1:0] {
      REG_WINDOW_MS      = 2'd0,
      REG_MAX_PER_WINDOW = 2'd1,
      REG_BLOCK_MS       = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_NEW       = 3'd0,
      ST_OK        = 3'd1,
      ST_ZERO      = 3'd2,
      ST_BLOCKED   = 3'd3,
      ST_RATE      = 3'd4,
      ST_UNTRACKED = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_READREC,
      S_EVAL,
      S_WRITE,
      S_RESPOND
   } state_type;

   typedef struct packed {
      logic [15:0] window_ms;
      logic [15:0] max_per_window;
      logic [31:0] block_ms;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0]  window_start;
      logic [TIME_W-1:0]  blocked_until;
      logic [COUNT_W-1:0] count;
   } rec_type;

   typedef struct packed {
      logic               blocked;
      logic               expired;
      logic               over;
      logic [COUNT_W-1:0] count_inc;
      logic [TIME_W-1:0]  block_end;
   } eval_type;

endpackage

[rtl/pscrl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pscrl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/pscrl_eval.sv]
// Evaluation stage: derives block, window and count results from one record.
module pscrl_eval (
   input  logic                    clock,
   input  logic                    enable,
   input  pscrl_pkg::rec_type      rec,
   input  logic [47:0]             now_ms,
   input  pscrl_pkg::cfg_type      cfg,
   output pscrl_pkg::eval_type     result
);
   import pscrl_pkg::*;

   eval_type          eval_ff;
   eval_type          eval_in;
   logic [TIME_W-1:0] elapsed;
   logic [TIME_W:0]   until_sum;

   always_comb begin
      eval_in = '0;
      eval_in.count_inc = (rec.count != COUNT_MAX) ? rec.count + 1'b1 : rec.count;
      eval_in.blocked   = rec.blocked_until > now_ms;
      elapsed           = now_ms - rec.window_start;
      // time running backwards counts as no elapsed time
      eval_in.expired   = (now_ms >= rec.window_start) &&
                          (elapsed > {{(TIME_W-16){1'b0}}, cfg.window_ms});
      eval_in.over      = eval_in.count_inc > cfg.max_per_window;
      until_sum         = {1'b0, now_ms} + {{(TIME_W-31){1'b0}}, cfg.block_ms};
      eval_in.block_end = until_sum[TIME_W] ? TIME_MAX : until_sum[TIME_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         eval_ff <= eval_in;
      end
   end

   assign result = eval_ff;
endmodule

[rtl/per_source_connection_rate_limiter.sv]
// A zero address is answered without a search. Any other address is looked up by a linear
// search, one address per cycle; a new source is answered when the search ends, a known one
// after its record is read, evaluated and written back. One request is handled at a time; a
// waiting response does not hold off the next request.
// Reset (synchronous): fill count cleared so the table reads as empty, registers
// back to window 1000 ms, limit 10, block 10000 ms; no RAM clearing pass.
module per_source_connection_rate_limiter #(
   parameter int ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_client_ip,
   input  logic [47:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_accept,
   output logic [2:0]  rsp_status,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import pscrl_pkg::*;

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [CW-1:0] FULL = CW'(ENTRIES);

   state_type         state_ff, state_in;
   cfg_type           cfg_ff;
   logic [ADDR_W-1:0] ip_ff, ip_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [CW-1:0]     scan_ff, scan_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic [IW-1:0]     cmp_idx_ff, cmp_idx_in;
   logic [IW-1:0]     hit_idx_ff, hit_idx_in;
   logic [CW-1:0]     used_ff, used_in;
   logic              res_accept_ff, res_accept_in;
   status_type        res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_accept_ff, rsp_accept_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic              addr_wr_en, addr_rd_en;
   logic [IW-1:0]     addr_wr_addr, addr_rd_addr;
   logic [ADDR_W-1:0] addr_rd_data;
   logic              rec_wr_en, rec_rd_en;
   logic [IW-1:0]     rec_wr_addr;
   rec_type           rec_wr_data, rec_rd_data;
   eval_type          eval_res;
   logic              eval_en;
   logic              hit_now;
   logic              slot_free;

   pscrl_ram #(.WIDTH(ADDR_W), .DEPTH(ENTRIES)) u_addr_ram (
      .clock   (clock),
      .wr_en   (addr_wr_en),
      .wr_addr (addr_wr_addr),
      .wr_data (ip_ff),
      .rd_en   (addr_rd_en),
      .rd_addr (addr_rd_addr),
      .rd_data (addr_rd_data)
   );

   pscrl_ram #(.WIDTH($bits(rec_type)), .DEPTH(ENTRIES)) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_wr_en),
      .wr_addr (rec_wr_addr),
      .wr_data (rec_wr_data),
      .rd_en   (rec_rd_en),
      .rd_addr (hit_idx_ff),
      .rd_data (rec_rd_data)
   );

   pscrl_eval u_eval (
      .clock  (clock),
      .enable (eval_en),
      .rec    (rec_rd_data),
      .now_ms (now_ff),
      .cfg    (cfg_ff),
      .result (eval_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_ms      <= WINDOW_MS_RESET;
         cfg_ff.max_per_window <= MAX_PER_WINDOW_RESET;
         cfg_ff.block_ms       <= BLOCK_MS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_WINDOW_MS:      cfg_ff.window_ms      <= csr_data[15:0];
            REG_MAX_PER_WINDOW: cfg_ff.max_per_window <= csr_data[15:0];
            REG_BLOCK_MS:       cfg_ff.block_ms       <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ip_ff         <= ip_in;
      now_ff        <= now_in;
      scan_ff       <= scan_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_idx_ff    <= hit_idx_in;
      res_accept_ff <= res_accept_in;
      res_status_ff <= res_status_in;
      rsp_accept_ff <= rsp_accept_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign hit_now   = cmp_valid_ff && (addr_rd_data == ip_ff);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      ip_in         = ip_ff;
      now_in        = now_ff;
      scan_in       = scan_ff;
      cmp_valid_in  = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      hit_idx_in    = hit_idx_ff;
      used_in       = used_ff;
      res_accept_in = res_accept_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_accept_in = rsp_accept_ff;
      rsp_status_in = rsp_status_ff;
      addr_wr_en    = 1'b0;
      addr_wr_addr  = used_ff[IW-1:0];
      addr_rd_en    = 1'b0;
      addr_rd_addr  = scan_ff[IW-1:0];
      rec_wr_en     = 1'b0;
      rec_wr_addr   = hit_idx_ff;
      rec_wr_data   = rec_rd_data;
      rec_rd_en     = 1'b0;
      eval_en       = 1'b0;
      req_stall     = 1'b1;

      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ip_in   = req_client_ip;
               now_in  = req_now_ms;
               scan_in = '0;
               if (req_client_ip == '0) begin
                  res_accept_in = 1'b0;
                  res_status_in = ST_ZERO;
                  state_in      = S_RESPOND;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            // read issued for scan_ff, compare lands in the next cycle on cmp_idx_ff
            if (scan_ff < used_ff) begin
               addr_rd_en   = 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = scan_ff[IW-1:0];
               scan_in      = scan_ff + 1'b1;
            end
            if (hit_now) begin
               cmp_valid_in = 1'b0;
               hit_idx_in   = cmp_idx_ff;
               state_in     = S_READREC;
            end else if (scan_ff == used_ff) begin
               cmp_valid_in  = 1'b0;
               res_accept_in = 1'b1;
               state_in      = S_RESPOND;
               if (used_ff >= FULL) begin
                  res_status_in = ST_UNTRACKED;
               end else begin
                  addr_wr_en                = 1'b1;
                  rec_wr_en                 = 1'b1;
                  rec_wr_addr               = used_ff[IW-1:0];
                  rec_wr_data.window_start  = now_ff;
                  rec_wr_data.blocked_until = '0;
                  rec_wr_data.count         = COUNT_W'(1);
                  used_in                   = used_ff + 1'b1;
                  res_status_in             = ST_NEW;
               end
            end
         end
         S_READREC: begin
            rec_rd_en = 1'b1;
            state_in  = S_EVAL;
         end
         S_EVAL: begin
            eval_en  = 1'b1;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            // record read data is still held: no read issued since
            rec_wr_en         = 1'b1;
            rec_wr_data.count = eval_res.count_inc;
            state_in          = S_RESPOND;
            if (eval_res.blocked) begin
               res_accept_in = 1'b0;
               res_status_in = ST_BLOCKED;
            end else if (eval_res.expired) begin
               rec_wr_data.window_start  = now_ff;
               rec_wr_data.count         = '0;
               if (eval_res.over) begin
                  rec_wr_data.blocked_until = eval_res.block_end;
                  res_accept_in             = 1'b0;
                  res_status_in             = ST_RATE;
               end else begin
                  rec_wr_data.blocked_until = '0;
                  res_accept_in             = 1'b1;
                  res_status_in             = ST_OK;
               end
            end else begin
               res_accept_in = 1'b1;
               res_status_in = ST_OK;
            end
         end
         S_RESPOND: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_accept_in = res_accept_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_accept = rsp_accept_ff;
   assign rsp_status = rsp_status_ff;
endmodule

[rtl/pscrl_checker.sv]
// Port-level checker for the rate limiter, bound to the top level.
module pscrl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_accept,
   input logic [2:0]  rsp_status
);
   import pscrl_pkg::*;

   // a held response beat keeps its contents
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_accept) && $stable(rsp_status))
      else $error("stalled response beat changed");

   // accept follows from the status code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_accept == ((rsp_status == ST_NEW) || (rsp_status == ST_OK) ||
                                    (rsp_status == ST_UNTRACKED))))
      else $error("accept disagrees with status");

   // one request in flight: the block is busy right after taking a beat
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");

   // no response beat straight out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind per_source_connection_rate_limiter pscrl_checker u_pscrl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_accept (rsp_accept),
   .rsp_status (rsp_status)
);

[verif/tb.sv]
// Self-checking testbench for the per-source connection rate limiter.
module tb;
   import pscrl_pkg::*;

   localparam int ENTRIES     = 256;
   localparam int HOT_SOURCES = 24;
   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 5000;
   localparam int MAX_REPORTS = 50;

   typedef struct {
      logic       accept;
      status_type status;
   } verdict_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_client_ip;
   logic [47:0] req_now_ms;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_accept;
   logic [2:0]  rsp_status;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   // predicted table and limits
   logic [31:0] src_addr          [ENTRIES];
   logic [47:0] src_window_start  [ENTRIES];
   logic [47:0] src_blocked_until [ENTRIES];
   logic [15:0] src_attempts      [ENTRIES];
   int          tracked_count;
   logic [15:0] lim_window;
   logic [15:0] lim_max;
   logic [31:0] lim_block;

   verdict_type expected_verdicts[$];
   verdict_type oldest;
   logic [31:0] hot_pool[HOT_SOURCES];
   logic [47:0] clock_ms;
   int          status_tally[6];
   int          attempts_sent;
   int          beats_checked;
   int          failures;
   int          idle_cycles;
   bit          sender_idling;
   bit          receiver_idling;
   bit          hold_request;

   per_source_connection_rate_limiter i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_client_ip (req_client_ip),
      .req_now_ms    (req_now_ms),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_accept    (rsp_accept),
      .rsp_status    (rsp_status),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void predict_verdict(input logic [31:0] ip, input logic [47:0] now,
                                           output logic acc, output status_type st);
      int          hit;
      logic [15:0] seen;
      logic [47:0] elapsed;
      logic [48:0] block_end;
      hit = -1;
      acc = 1'b1;
      st  = ST_OK;
      if (ip == '0) begin
         acc = 1'b0;
         st  = ST_ZERO;
         return;
      end
      for (int i = 0; i < tracked_count; i++)
         if (hit < 0 && src_addr[i] == ip) hit = i;
      if (hit < 0) begin
         if (tracked_count >= ENTRIES) begin
            st = ST_UNTRACKED;
            return;
         end
         src_addr[tracked_count]          = ip;
         src_window_start[tracked_count]  = now;
         src_blocked_until[tracked_count] = '0;
         src_attempts[tracked_count]      = 16'd1;
         tracked_count++;
         st = ST_NEW;
         return;
      end
      if (src_attempts[hit] != COUNT_MAX) src_attempts[hit]++;
      if (src_blocked_until[hit] > now) begin
         acc = 1'b0;
         st  = ST_BLOCKED;
         return;
      end
      // a time earlier than the window start counts as no time elapsed
      elapsed = (now >= src_window_start[hit]) ? now - src_window_start[hit] : '0;
      if (elapsed > {32'd0, lim_window}) begin
         seen = src_attempts[hit];
         src_window_start[hit]  = now;
         src_attempts[hit]      = '0;
         src_blocked_until[hit] = '0;
         if (seen > lim_max) begin
            block_end = {1'b0, now} + {17'd0, lim_block};
            src_blocked_until[hit] = block_end[48] ? TIME_MAX : block_end[47:0];
            acc = 1'b0;
            st  = ST_RATE;
         end
      end
   endfunction

   // Offers one attempt, records its verdict once taken, then maybe idles.
   // With no idle gap valid stays high for the next call.
   task automatic send_attempt(input logic [31:0] ip, input logic [47:0] now);
      logic       acc;
      status_type st;
      int         pick;
      int         gap;
      req_valid     <= 1'b1;
      req_client_ip <= ip;
      req_now_ms    <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_verdict(ip, now, acc, st);
      expected_verdicts.push_back('{accept: acc, status: st});
      status_tally[int'(st)]++;
      attempts_sent++;
      gap = 0;
      if (sender_idling) begin
         pick = $urandom_range(0, 99);
         if (pick >= 92) gap = $urandom_range(8, 40);
         else if (pick >= 60) gap = $urandom_range(1, 3);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Sender goes quiet until every verdict has been checked.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limits(input logic [15:0] window, input logic [15:0] max_count,
                               input logic [31:0] block);
      settle();
      csr_write <= 1'b1;
      csr_index <= REG_WINDOW_MS;
      csr_data  <= {16'($urandom), window};
      @(posedge clock);
      csr_index <= REG_MAX_PER_WINDOW;
      csr_data  <= {16'($urandom), max_count};
      @(posedge clock);
      csr_index <= REG_BLOCK_MS;
      csr_data  <= block;
      @(posedge clock);
      csr_write  <= 1'b0;
      lim_window = window;
      lim_max    = max_count;
      lim_block  = block;
   endtask

   task automatic test_long_window();
      logic [47:0] t0;
      sender_idling   = 1'b0;
      receiver_idling = 1'b0;
      write_limits(16'd65535, 16'd16, 32'd1000);
      t0 = 48'h0000_1000_0000;
      send_attempt(32'h0A00_0001, t0);
      // pile attempts into one long window, then let it run out over the limit
      for (int k = 0; k < 24; k++) send_attempt(32'h0A00_0001, t0);
      send_attempt(32'h0A00_0001, t0 + 48'd65536);
      send_attempt(32'h0A00_0001, t0 + 48'd66535);
      settle();
   endtask

   task automatic test_address_rules();
      sender_idling   = 1'b1;
      receiver_idling = 1'b1;
      send_attempt(32'h0000_0000, 48'd0);
      send_attempt(32'hFFFF_FFFF, 48'd0);
      send_attempt(32'h0000_0001, 48'd0);
      send_attempt(32'hFFFF_FFFF, 48'd5);
      send_attempt(32'h0000_0000, TIME_MAX);
      send_attempt(32'h8000_0000, TIME_MAX);
      send_attempt(32'h8000_0000, TIME_MAX);
   endtask

   task automatic test_window_and_block();
      write_limits(16'd100, 16'd2, 32'd500);
      send_attempt(32'h0A00_0002, 48'd10000);
      send_attempt(32'h0A00_0002, 48'd10050);
      send_attempt(32'h0A00_0002, 48'd10100);
      send_attempt(32'h0A00_0002, 48'd10101);
      send_attempt(32'h0A00_0002, 48'd10300);
      send_attempt(32'h0A00_0002, 48'd10600);
      send_attempt(32'h0A00_0002, 48'd10601);
      send_attempt(32'h0A00_0003, 48'd20000);
      send_attempt(32'h0A00_0003, 48'd20101);
      send_attempt(32'h0A00_0003, 48'd5);
      // zero window, zero limit, zero block: block ends the moment it starts
      write_limits(16'd0, 16'd0, 32'd0);
      send_attempt(32'h0A00_0003, 48'd20101);
      send_attempt(32'h0A00_0003, 48'd20102);
      send_attempt(32'h0A00_0003, 48'd20102);
      // block end clamps at the top of the time range
      write_limits(16'd1, 16'd0, 32'hFFFF_FFFF);
      send_attempt(32'h0A00_0004, TIME_MAX - 48'd10);
      send_attempt(32'h0A00_0004, TIME_MAX - 48'd8);
      send_attempt(32'h0A00_0004, TIME_MAX - 48'd1);
      send_attempt(32'h0A00_0004, TIME_MAX);
   endtask

   task automatic test_backpressure();
      write_limits(16'd20, 16'd3, 32'd50);
      sender_idling   = 1'b0;
      receiver_idling = 1'b0;
      clock_ms        = 48'd500000;
      hold_request    = 1'b1;
      for (int k = 0; k < 12; k++) begin
         clock_ms += 48'd3;
         send_attempt(32'hC0A8_0000 + 32'(k % 3), clock_ms);
      end
      settle();
   endtask

   task automatic run_bursts(input int count, input int fresh_pct);
      int          sent;
      int          pick;
      int          len;
      int          step_max;
      logic [31:0] src;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            send_attempt(32'h0, clock_ms);
            sent++;
         end else begin
            src = (pick < 4 + fresh_pct) ? $urandom : hot_pool[$urandom_range(0, HOT_SOURCES - 1)];
            len = $urandom_range(1, 16);
            step_max = int'(lim_window) / 4 + 1;
            for (int k = 0; k < len; k++) begin
               clock_ms += 48'($urandom_range(0, step_max));
               send_attempt(src, clock_ms);
               sent++;
            end
         end
         pick = $urandom_range(0, 99);
         if (pick < 50) clock_ms += {32'd0, lim_window} + 48'($urandom_range(1, 50));
         else if (pick < 65) clock_ms += {16'd0, lim_block} + 48'd1;
         else if (pick < 70) clock_ms -= 48'($urandom_range(1, 5000));
      end
   endtask

   task automatic test_random_traffic();
      logic [15:0] window;
      logic [15:0] max_count;
      logic [31:0] block;
      for (int i = 0; i < HOT_SOURCES; i++) begin
         hot_pool[i] = $urandom;
         if (hot_pool[i] == '0) hot_pool[i] = 32'h0000_0101;
      end
      for (int phase = 0; phase < 5; phase++) begin
         window    = WINDOW_MS_RESET;
         max_count = MAX_PER_WINDOW_RESET;
         block     = BLOCK_MS_RESET;
         if (phase != 0) begin
            case ($urandom_range(0, 3))
               0: window = 16'd1;
               1: window = 16'($urandom_range(2, 64));
               2: window = 16'hFFFF;
               default: window = 16'($urandom_range(1, 65535));
            endcase
            case ($urandom_range(0, 3))
               0: max_count = 16'd0;
               3: max_count = 16'hFFFF;
               default: max_count = 16'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 3))
               0: block = 32'd0;
               1: block = 32'($urandom_range(1, 200));
               2: block = 32'hFFFF_FFFF;
               default: block = $urandom;
            endcase
         end
         write_limits(window, max_count, block);
         if (phase != 0 && $urandom_range(0, 1) == 1) clock_ms = {16'($urandom), 32'($urandom)};
         sender_idling   = (phase != 3);
         receiver_idling = (phase != 3);
         run_bursts(40, 15);
      end
   endtask

   task automatic test_table_full();
      write_limits(16'd50, 16'd3, 32'd100);
      sender_idling   = 1'b1;
      receiver_idling = 1'b1;
      while (tracked_count < ENTRIES) begin
         clock_ms += 48'd1;
         send_attempt($urandom, clock_ms);
      end
      send_attempt(src_addr[0], clock_ms);
      send_attempt(src_addr[ENTRIES-1], clock_ms);
      run_bursts(70, 40);
   endtask

   // receiver side: random stalls, plus one long hold-off on request
   initial begin
      int pick;
      int stall_left;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = HOLD_CYCLES;
         end else if (stall_left == 0 && receiver_idling) begin
            pick = $urandom_range(0, 99);
            if (pick >= 96) stall_left = $urandom_range(15, 60);
            else if (pick >= 70) stall_left = $urandom_range(1, 3);
         end
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_checked++;
         if (expected_verdicts.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $error("response beat with nothing expected: accept %0b status %0d",
                      rsp_accept, rsp_status);
         end else begin
            oldest = expected_verdicts.pop_front();
            if (rsp_accept !== oldest.accept) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $error("accept: expected %0b, got %0b", oldest.accept, rsp_accept);
            end
            if (rsp_status !== oldest.status) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $error("status: expected %0d, got %0d", oldest.status, rsp_status);
            end
         end
      end
   end

   // ends the run if no beat moves on either side for too long
   initial begin
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("tb failed");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_client_ip   = '0;
      req_now_ms      = '0;
      csr_write       = 1'b0;
      csr_index       = REG_WINDOW_MS;
      csr_data        = '0;
      hold_request    = 1'b0;
      sender_idling   = 1'b0;
      receiver_idling = 1'b0;
      tracked_count   = 0;
      lim_window      = WINDOW_MS_RESET;
      lim_max         = MAX_PER_WINDOW_RESET;
      lim_block       = BLOCK_MS_RESET;
      clock_ms        = '0;
      attempts_sent   = 0;
      beats_checked   = 0;
      failures        = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_long_window();
      test_address_rules();
      test_window_and_block();
      test_backpressure();
      test_random_traffic();
      test_table_full();
      settle();
      repeat (300) @(posedge clock);
      $display("covered %0d attempts: %0d new, %0d ok, %0d zero address, %0d blocked,",
               attempts_sent, status_tally[ST_NEW], status_tally[ST_OK],
               status_tally[ST_ZERO], status_tally[ST_BLOCKED]);
      $display("  %0d rate limited, %0d untracked; %0d sources tracked, %0d beats checked",
               status_tally[ST_RATE], status_tally[ST_UNTRACKED], tracked_count,
               beats_checked);
      if (failures == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
